@@ design/rau_pkg.sv @@
// shared types and constants of the rational arithmetic unit
package rau_pkg;

  // width of every numerator and denominator field on the ports
  localparam int unsigned DATA_W = 32;

  // default operand width
  localparam int unsigned OPERAND_WIDTH_DEF = 32;

  // operation codes
  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MOD = 3'd4,
    OP_EQ  = 3'd5,
    OP_GT  = 3'd6
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ZERO  = 2'd1,
    ST_OVF   = 2'd2,
    ST_BADOP = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MUL_X,
    S_MUL_Y,
    S_MUL_D,
    S_COMBINE,
    S_NEG,
    S_MOD_DIV,
    S_GCD,
    S_DIV_NUM,
    S_DIV_DEN,
    S_FINISH,
    S_DONE
  } state_e;

  // input transaction
  typedef struct packed {
    op_e                      op;
    logic signed [DATA_W-1:0] a_numerator;
    logic        [DATA_W-1:0] a_denominator;
    logic signed [DATA_W-1:0] b_numerator;
    logic        [DATA_W-1:0] b_denominator;
  } in_t;

  // output transaction
  typedef struct packed {
    logic signed [DATA_W-1:0] result_numerator;
    logic        [DATA_W-1:0] result_denominator;
    logic                     truth;
    status_e                  status;
  } out_t;

  // flags from the shared add/subtract unit
  typedef struct packed {
    logic borrow;
    logic zero;
  } alu_flags_t;

endpackage

@@ design/rau_mul.sv @@
// shared unsigned multiplier, operand width by operand width
module rau_mul #(
  parameter int unsigned W = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic [2*W-1:0] p_o
);

  // full-width product, registered by the caller
  assign p_o = (2*W)'(a_i) * (2*W)'(b_i);

endmodule

@@ design/rau_alu.sv @@
// shared add/subtract and compare unit
module rau_alu #(
  parameter int unsigned AW = 2 * rau_pkg::OPERAND_WIDTH_DEF + 1
) (
  input  logic [AW-1:0]       a_i,
  input  logic [AW-1:0]       b_i,
  input  logic                sub_i,
  output logic [AW-1:0]       res_o,
  output rau_pkg::alu_flags_t flags_o
);

  logic [AW:0] sum;

  // a + b, or a + ~b + 1 for subtract
  assign sum = {1'b0, a_i} + {1'b0, (sub_i ? ~b_i : b_i)} + (AW+1)'(sub_i);

  assign res_o          = sum[AW-1:0];
  assign flags_o.borrow = sub_i & ~sum[AW];
  assign flags_o.zero   = ~|sum[AW-1:0];

endmodule

@@ design/rational_arithmetic_unit_core.sv @@
// Rational ALU: one transaction at a time, W = OPERAND_WIDTH, products 2W bits wide.
// Compares run through check, the three products and combine before the done state; arithmetic
// adds binary-GCD steps and two bit-serial divisions (and one more division first for modulo).
// The run time is set by the bit-serial divider and GCD loop on the one shared
// 2W+1 bit add/subtract unit; a new transaction is taken as soon as the sequencer is idle.
// Reset clears the sequencer and the output valid; no transaction is lost after it.
module rational_arithmetic_unit_core #(
  parameter int unsigned OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rau_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rau_pkg::out_t out_data_o
);

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned WW = 2 * W;
  localparam int unsigned AW = WW + 1;
  localparam int unsigned CW = $clog2(WW);
  localparam int unsigned DW = rau_pkg::DATA_W;
  localparam logic [CW-1:0] CNT_LAST = CW'(WW - 1);
  localparam logic [WW-1:0] NUM_LIM  = WW'(1) << (W - 1);

  rau_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  rau_pkg::out_t   out_q, out_d;
  rau_pkg::out_t   res_q, res_d;
  rau_pkg::op_e    op_q, op_d;
  logic            sa_q, sa_d, sb_q, sb_d, sr_q, sr_d;
  logic [W-1:0]    ma_q, ma_d, mb_q, mb_d, da_q, da_d, db_q, db_d;
  logic [WW-1:0]   num_q, num_d, y_q, y_d, den_q, den_d;
  logic [WW-1:0]   u_q, u_d, v_q, v_d, rem_q, rem_d, quo_q, quo_d;
  logic [CW-1:0]   cnt_q, cnt_d;

  logic [W-1:0]        mul_a, mul_b;
  logic [WW-1:0]       mul_p;
  logic [AW-1:0]       alu_a, alu_b, alu_res;
  logic                alu_sub;
  rau_pkg::alu_flags_t alu_flags;

  logic          in_acc;
  logic          sb_eff, sa_nz, sb_nz, gt_flag, op_known, ovf;
  logic [W-1:0]  a_raw, b_raw;
  logic [WW-1:0] div_sor, rem_next, quo_next;
  logic [AW-1:0] r_shift;
  logic          div_ge;
  logic signed [W-1:0] n_signed;

  // handshake
  assign in_stall_o  = (state_q != rau_pkg::S_IDLE);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // shared units
  rau_mul #(.W(W)) u_mul (
    .a_i (mul_a),
    .b_i (mul_b),
    .p_o (mul_p)
  );

  rau_alu #(.AW(AW)) u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .sub_i   (alu_sub),
    .res_o   (alu_res),
    .flags_o (alu_flags)
  );

  // sign helpers
  assign sb_eff = (op_q == rau_pkg::OP_SUB) ? ~sb_q : sb_q;
  assign sa_nz  = sa_q & (|ma_q);
  assign sb_nz  = sb_q & (|mb_q);
  assign gt_flag = (sa_nz != sb_nz) ? ~sa_nz :
                   (sa_nz ? alu_flags.borrow : (~alu_flags.borrow & ~alu_flags.zero));

  // restoring divider step
  assign div_sor  = (state_q == rau_pkg::S_MOD_DIV) ? y_q : v_q;
  assign r_shift  = {rem_q, quo_q[WW-1]};
  assign div_ge   = ~alu_flags.borrow;
  assign rem_next = div_ge ? alu_res[WW-1:0] : r_shift[WW-1:0];
  assign quo_next = {quo_q[WW-2:0], div_ge};

  // input numerators, low W bits before the magnitude is taken
  assign a_raw = in_data_i.a_numerator[W-1:0];
  assign b_raw = in_data_i.b_numerator[W-1:0];

  // operand selection for the shared units
  always_comb begin
    mul_a   = ma_q;
    mul_b   = db_q;
    alu_a   = AW'(num_q);
    alu_b   = AW'(y_q);
    alu_sub = 1'b1;
    case (state_q)
      rau_pkg::S_MUL_X: begin
        mul_a = ma_q;
        mul_b = (op_q == rau_pkg::OP_MUL) ? mb_q : db_q;
      end
      rau_pkg::S_MUL_Y: begin
        mul_a = mb_q;
        mul_b = da_q;
      end
      rau_pkg::S_MUL_D: begin
        mul_a = da_q;
        mul_b = (op_q == rau_pkg::OP_DIV) ? mb_q : db_q;
      end
      rau_pkg::S_COMBINE: begin
        alu_sub = ~(((op_q == rau_pkg::OP_ADD) || (op_q == rau_pkg::OP_SUB)) &&
                    (sa_q == sb_eff));
      end
      rau_pkg::S_NEG: begin
        alu_a = AW'(y_q);
        alu_b = AW'(num_q);
      end
      rau_pkg::S_GCD: begin
        alu_a = AW'(u_q);
        alu_b = AW'(v_q);
      end
      rau_pkg::S_MOD_DIV, rau_pkg::S_DIV_NUM, rau_pkg::S_DIV_DEN: begin
        alu_a = r_shift;
        alu_b = AW'(div_sor);
      end
      default: begin
        alu_sub = 1'b1;
      end
    endcase
  end

  // known operation codes
  always_comb begin
    case (op_q)
      rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_MUL, rau_pkg::OP_DIV,
      rau_pkg::OP_MOD, rau_pkg::OP_EQ, rau_pkg::OP_GT: op_known = 1'b1;
      default: op_known = 1'b0;
    endcase
  end

  // final overflow check and signed numerator
  assign ovf = (|den_q[WW-1:W]) || (num_q > NUM_LIM) || (~sr_q && (num_q == NUM_LIM));
  assign n_signed = sr_q ? signed'(~num_q[W-1:0] + W'(1)) : signed'(num_q[W-1:0]);

  // sequencer: next state and datapath updates
  always_comb begin
    state_d     = state_q;
    out_d       = out_q;
    res_d       = res_q;
    op_d        = op_q;
    sa_d        = sa_q;
    sb_d        = sb_q;
    sr_d        = sr_q;
    ma_d        = ma_q;
    mb_d        = mb_q;
    da_d        = da_q;
    db_d        = db_q;
    num_d       = num_q;
    y_d         = y_q;
    den_d       = den_q;
    u_d         = u_q;
    v_d         = v_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q & out_stall_i;

    case (state_q)
      rau_pkg::S_IDLE: begin
        if (in_acc) begin
          op_d    = in_data_i.op;
          sa_d    = a_raw[W-1];
          sb_d    = b_raw[W-1];
          ma_d    = a_raw[W-1] ? (~a_raw + W'(1)) : a_raw;
          mb_d    = b_raw[W-1] ? (~b_raw + W'(1)) : b_raw;
          da_d    = in_data_i.a_denominator[W-1:0];
          db_d    = in_data_i.b_denominator[W-1:0];
          state_d = rau_pkg::S_CHECK;
        end
      end
      // error screening, result preset to 0/1
      rau_pkg::S_CHECK: begin
        res_d.result_numerator   = '0;
        res_d.result_denominator = DW'(1);
        res_d.truth              = 1'b0;
        res_d.status             = rau_pkg::ST_OK;
        if (!op_known) begin
          res_d.status = rau_pkg::ST_BADOP;
          state_d      = rau_pkg::S_DONE;
        end else if ((~|da_q) || (~|db_q)) begin
          res_d.status = rau_pkg::ST_ZERO;
          state_d      = rau_pkg::S_DONE;
        end else if (((op_q == rau_pkg::OP_DIV) || (op_q == rau_pkg::OP_MOD)) &&
                     (~|mb_q)) begin
          res_d.status = rau_pkg::ST_ZERO;
          state_d      = rau_pkg::S_DONE;
        end else begin
          state_d = rau_pkg::S_MUL_X;
        end
      end
      // three products through the one multiplier
      rau_pkg::S_MUL_X: begin
        num_d   = mul_p;
        state_d = rau_pkg::S_MUL_Y;
      end
      rau_pkg::S_MUL_Y: begin
        y_d     = mul_p;
        state_d = rau_pkg::S_MUL_D;
      end
      rau_pkg::S_MUL_D: begin
        den_d   = mul_p;
        state_d = rau_pkg::S_COMBINE;
      end
      // combine cross products per operation
      rau_pkg::S_COMBINE: begin
        case (op_q)
          rau_pkg::OP_EQ: begin
            res_d.truth = (sa_nz == sb_nz) && alu_flags.zero;
            state_d     = rau_pkg::S_DONE;
          end
          rau_pkg::OP_GT: begin
            res_d.truth = gt_flag;
            state_d     = rau_pkg::S_DONE;
          end
          rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
            if (alu_flags.borrow) begin
              state_d = rau_pkg::S_NEG;
            end else begin
              num_d   = alu_res[WW-1:0];
              u_d     = alu_res[WW-1:0];
              v_d     = den_q;
              sr_d    = sa_q;
              state_d = rau_pkg::S_GCD;
            end
          end
          rau_pkg::OP_MUL, rau_pkg::OP_DIV: begin
            u_d     = num_q;
            v_d     = den_q;
            sr_d    = sa_q ^ sb_q;
            state_d = rau_pkg::S_GCD;
          end
          rau_pkg::OP_MOD: begin
            sr_d    = sa_q;
            quo_d   = num_q;
            rem_d   = '0;
            cnt_d   = '0;
            state_d = rau_pkg::S_MOD_DIV;
          end
          default: begin
            state_d = rau_pkg::S_DONE;
          end
        endcase
      end
      // opposite signs with the second magnitude larger
      rau_pkg::S_NEG: begin
        num_d   = alu_res[WW-1:0];
        u_d     = alu_res[WW-1:0];
        v_d     = den_q;
        sr_d    = sb_eff;
        state_d = rau_pkg::S_GCD;
      end
      // truncating remainder of the cross products
      rau_pkg::S_MOD_DIV: begin
        rem_d = rem_next;
        quo_d = quo_next;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CNT_LAST) begin
          num_d   = rem_next;
          u_d     = rem_next;
          v_d     = den_q;
          state_d = rau_pkg::S_GCD;
        end
      end
      // binary gcd, common factors of two stripped from num and den directly
      rau_pkg::S_GCD: begin
        if (~|u_q) begin
          quo_d   = num_q;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = rau_pkg::S_DIV_NUM;
        end else if (~u_q[0] && ~v_q[0]) begin
          u_d   = u_q >> 1;
          v_d   = v_q >> 1;
          num_d = num_q >> 1;
          den_d = den_q >> 1;
        end else if (~u_q[0]) begin
          u_d = u_q >> 1;
        end else if (~v_q[0]) begin
          v_d = v_q >> 1;
        end else if (!alu_flags.borrow) begin
          u_d = alu_res[WW-1:0];
        end else begin
          u_d = v_q;
          v_d = u_q;
        end
      end
      // numerator divided by the odd gcd part
      rau_pkg::S_DIV_NUM: begin
        rem_d = rem_next;
        quo_d = quo_next;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CNT_LAST) begin
          num_d   = quo_next;
          quo_d   = den_q;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = rau_pkg::S_DIV_DEN;
        end
      end
      // denominator divided by the odd gcd part
      rau_pkg::S_DIV_DEN: begin
        rem_d = rem_next;
        quo_d = quo_next;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CNT_LAST) begin
          den_d   = quo_next;
          state_d = rau_pkg::S_FINISH;
        end
      end
      // range check of the reduced fraction
      rau_pkg::S_FINISH: begin
        if (ovf) begin
          res_d.status = rau_pkg::ST_OVF;
        end else begin
          res_d.result_numerator   = DW'(n_signed);
          res_d.result_denominator = DW'(den_q[W-1:0]);
        end
        state_d = rau_pkg::S_DONE;
      end
      // hand the result to the output register
      rau_pkg::S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = rau_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = rau_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rau_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    res_q <= res_d;
    op_q  <= op_d;
    sa_q  <= sa_d;
    sb_q  <= sb_d;
    sr_q  <= sr_d;
    ma_q  <= ma_d;
    mb_q  <= mb_d;
    da_q  <= da_d;
    db_q  <= db_d;
    num_q <= num_d;
    y_q   <= y_d;
    den_q <= den_d;
    u_q   <= u_d;
    v_q   <= v_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    cnt_q <= cnt_d;
  end

  // accepted transaction starts the sequencer
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("sequencer did not start on accepted transaction");

  // output register only loads from the done state
  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o)) |-> $past(state_q == rau_pkg::S_DONE))
    else $error("output loaded outside done state");

  // every result has a nonzero denominator
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.result_denominator != '0))
    else $error("result denominator is zero");

  // a true compare carries ok status and a zero numerator
  a_truth_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.truth) |->
      ((out_data_o.status == rau_pkg::ST_OK) && (out_data_o.result_numerator == '0)))
    else $error("truth set on non-compare result");

  // gcd divisor operand never reaches zero
  a_gcd_v_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rau_pkg::S_GCD) |-> (v_q != '0))
    else $error("gcd operand v is zero");

endmodule
